// ----- rtl/mfhd_pkg.sv -----
// Shared constants and types for the MQTT fixed-header deframer.
package mfhd_pkg;

  localparam int MaxLengthBytes = 4;
  localparam int LenW = 28;
  localparam int CntW = 3;

  // Parser phases.
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhLength  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  // Status codes.
  localparam logic [1:0] StBusy        = 2'd0;
  localparam logic [1:0] StOk          = 2'd1;
  localparam logic [1:0] StMalformed   = 2'd2;
  localparam logic [1:0] StUnsupported = 2'd3;

  // One bit per packet type that the client accepts: 2-7, 9, 11, 12 and 13.
  localparam logic [15:0] AcceptedTypes = 16'h3AFC;

  typedef struct packed {
    logic [3:0]      packet_type;
    logic [3:0]      packet_flags;
    logic [LenW-1:0] body_length;
    logic            length_known;
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic            packet_done;
    logic [1:0]      status;
  } result_t;

endpackage

// ----- rtl/mfhd_parser.sv -----
// Per-byte fixed-header parser: state registers and the next-state logic.
module mfhd_parser
  import mfhd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic [7:0] rx_byte,
  output result_t result
);

  logic [1:0]      phase, phase_next;
  logic [7:0]      command_byte, command_byte_next;
  logic [LenW-1:0] length_acc, length_acc_next;
  logic [CntW-1:0] length_count, length_count_next;
  logic [LenW-1:0] bytes_to_go, bytes_to_go_next;

  logic [LenW-1:0] group_shifted;
  logic [LenW-1:0] acc_sum;
  logic [CntW-1:0] count_inc;
  logic [LenW-1:0] btg_dec;
  logic [1:0]      final_status;

  always_comb begin
    unique case (length_count[1:0])
      2'd0:    group_shifted = {21'd0, rx_byte[6:0]};
      2'd1:    group_shifted = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    group_shifted = {7'd0, rx_byte[6:0], 14'd0};
      default: group_shifted = {rx_byte[6:0], 21'd0};
    endcase
  end

  // Groups never overlap, so accumulation is a plain OR.
  assign acc_sum      = length_acc | group_shifted;
  assign count_inc    = length_count + CntW'(1);
  assign btg_dec      = bytes_to_go - LenW'(1);
  assign final_status = AcceptedTypes[command_byte[7:4]] ? StOk : StUnsupported;

  always_comb begin
    phase_next        = phase;
    command_byte_next = command_byte;
    length_acc_next   = length_acc;
    length_count_next = length_count;
    bytes_to_go_next  = bytes_to_go;

    result.body_length   = '0;
    result.length_known  = 1'b0;
    result.payload_byte  = '0;
    result.payload_valid = 1'b0;
    result.packet_done   = 1'b0;
    result.status        = StBusy;

    unique case (phase)
      PhLength: begin
        length_acc_next   = acc_sum;
        length_count_next = count_inc;
        if (rx_byte[7]) begin
          if (count_inc >= CntW'(MaxLengthBytes)) begin
            result.packet_done = 1'b1;
            result.status      = StMalformed;
            phase_next         = PhIdle;
            length_acc_next    = '0;
            length_count_next  = '0;
            bytes_to_go_next   = '0;
          end
        end else begin
          result.length_known = 1'b1;
          result.body_length  = acc_sum;
          if (acc_sum == '0) begin
            result.packet_done = 1'b1;
            result.status      = final_status;
            phase_next         = PhIdle;
            length_acc_next    = '0;
            length_count_next  = '0;
            bytes_to_go_next   = '0;
          end else begin
            bytes_to_go_next = acc_sum;
            phase_next       = PhPayload;
          end
        end
      end
      PhPayload: begin
        result.length_known  = 1'b1;
        result.body_length   = length_acc;
        result.payload_byte  = rx_byte;
        result.payload_valid = 1'b1;
        bytes_to_go_next     = btg_dec;
        if (btg_dec == '0) begin
          result.packet_done = 1'b1;
          result.status      = final_status;
          phase_next         = PhIdle;
          length_acc_next    = '0;
          length_count_next  = '0;
        end
      end
      default: begin
        // Idle, and the unused phase code: this byte is a command byte.
        command_byte_next = rx_byte;
        phase_next        = PhLength;
        length_acc_next   = '0;
        length_count_next = '0;
        bytes_to_go_next  = '0;
      end
    endcase

    result.packet_type  = command_byte_next[7:4];
    result.packet_flags = command_byte_next[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhIdle;
      command_byte <= '0;
      length_acc   <= '0;
      length_count <= '0;
      bytes_to_go  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      command_byte <= command_byte_next;
      length_acc   <= length_acc_next;
      length_count <= length_count_next;
      bytes_to_go  <= bytes_to_go_next;
    end
  end

  a_payload_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PhPayload |-> bytes_to_go != '0)
    else $error("payload phase entered with nothing left to receive");

  a_length_count_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PhLength |-> length_count < CntW'(MaxLengthBytes))
    else $error("length byte count ran past its limit");

  a_malformed_not_known: assert property (@(posedge clk) disable iff (rst)
    step && result.status == StMalformed |-> !result.length_known && result.packet_done)
    else $error("malformed length reported with a known length");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.packet_done |=> phase == PhIdle)
    else $error("parser did not return to idle after a finished packet");

endmodule

// ----- rtl/mqtt_fixed_header_deframer_top.sv -----
// MQTT fixed-header deframer: input register, parser and result register.
//
// Takes one received byte per request and returns exactly one result per
// byte. A byte can be accepted on every clock while the input side does not
// stall. The byte is captured in the input register at the accepting edge;
// when the parser advances, its state update and the result for that byte
// are loaded at the same edge. The input side stalls only while the result
// register holds a result that has not yet been taken.
module mqtt_fixed_header_deframer_top
  import mfhd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      packet_type,
  output logic [3:0]      packet_flags,
  output logic [LenW-1:0] body_length,
  output logic            length_known,
  output logic [7:0]      payload_byte,
  output logic            payload_valid,
  output logic            packet_done,
  output logic [1:0]      status
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  result_t    result;
  result_t    out_q;

  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

  mfhd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (held_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign packet_type   = out_q.packet_type;
  assign packet_flags  = out_q.packet_flags;
  assign body_length   = out_q.body_length;
  assign length_known  = out_q.length_known;
  assign payload_byte  = out_q.payload_byte;
  assign payload_valid = out_q.payload_valid;
  assign packet_done   = out_q.packet_done;
  assign status        = out_q.status;

endmodule
